[rtl/scs_pkg.sv]
// scs_pkg: shared types and constants for the sorted counted store
// holds transfer payload structs, command and status codes, sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  // fixed field widths of the channels
  localparam int TYPE_FIELD_W  = 16;
  localparam int PORT_FIELD_W  = 4;
  localparam int ENTRIES_W     = 5;
  localparam int MASK_W        = 12;
  localparam int PORT_SPAN     = 2 ** PORT_FIELD_W;

  // parameter defaults
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_NUM_PORTS   = 12;
  localparam int DEF_TYPE_BITS   = 16;
  localparam int DEF_COUNT_BITS  = 16;

  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_DISPENSE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_DISPENSED = 3'd1,
    STAT_NOT_TAKEN = 3'd2,
    STAT_NOTHING   = 3'd3,
    STAT_DROPPED   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                    command;
    logic [TYPE_FIELD_W-1:0] type_code;
    logic [PORT_FIELD_W-1:0] port;
    logic                    downstream_ready;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [TYPE_FIELD_W-1:0] item_type;
    logic [ENTRIES_W-1:0]    entries_used;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHUP_RD,
    ST_SHUP_WR,
    ST_INS,
    ST_MOD,
    ST_DISP_CHK,
    ST_SHDN_RD,
    ST_SHDN_WR
  } state_t;

endpackage

`default_nettype wire

[rtl/sorted_counted_store_rr_dispense.sv]
// sorted_counted_store_rr_dispense: sorted type/count table with round-robin dispense
// one entry memory walked by a small sequencer; uses scs_pkg
//
//   channel | ports                         | handshake
//   input   | start, busy, in_data          | transfer when start & !busy
//   result  | out_strobe, out_data          | one-cycle strobe, never stalled
//   config  | cfg_valid, cfg_ready, cfg_data| transfer when cfg_valid & cfg_ready
//
// each search or shift step is a read cycle and a use cycle; the receiver cannot
// stall results. add: search entries in order, shift larger ones up, place the new one
// dispense: reduce the pointer modulo the entry count, offer the entry at it, and shift
// entries down when one empties; with nothing to offer the result follows the transfer
// synchronous active-low reset clears entry count, pointers and enable mask; the
// table memory has no reset, only entries below the entry count are ever used
`timescale 1ns / 1ps
`default_nettype none

module sorted_counted_store_rr_dispense #(
  parameter int TABLE_DEPTH = scs_pkg::DEF_TABLE_DEPTH,
  parameter int NUM_PORTS   = scs_pkg::DEF_NUM_PORTS,
  parameter int TYPE_BITS   = scs_pkg::DEF_TYPE_BITS,
  parameter int COUNT_BITS  = scs_pkg::DEF_COUNT_BITS
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire scs_pkg::in_item_t          in_data,
  output logic                            out_strobe,
  output scs_pkg::out_item_t              out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [scs_pkg::MASK_W-1:0]       cfg_data
);

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W   = TYPE_BITS + COUNT_BITS;
  localparam int PIDX_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // entry memory: type in the upper bits, count in the lower
  logic [ENT_W-1:0]  mem [TABLE_DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;

  // round-robin pointers, one per port
  logic [CNT_W-1:0]  ptr_tab_r [NUM_PORTS];
  logic              ptr_we;
  logic [CNT_W-1:0]  ptr_wdata;

  scs_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [TYPE_BITS-1:0] code_r, code_nxt;
  logic [PIDX_W-1:0]   port_r, port_nxt;
  logic                rdy_r, rdy_nxt;
  logic [scs_pkg::MASK_W-1:0] mask_r;
  logic                out_strobe_r, out_strobe_nxt;
  scs_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [scs_pkg::PORT_SPAN-1:0] mask_ext;
  logic [TYPE_BITS-1:0]  rd_type;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] count_dec;
  logic                  tab_full;
  logic                  port_ok;

  assign mask_ext  = {{(scs_pkg::PORT_SPAN - scs_pkg::MASK_W){1'b0}}, mask_r};
  assign rd_type   = rd_data_r[ENT_W-1:COUNT_BITS];
  assign rd_count  = rd_data_r[COUNT_BITS-1:0];
  assign count_dec = rd_count - COUNT_BITS'(1);
  assign tab_full  = (total_r == CNT_W'(TABLE_DEPTH));
  assign port_ok   = (32'(in_data.port) < NUM_PORTS) && mask_ext[in_data.port];

  assign busy       = (state_r != scs_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // pointer table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        ptr_tab_r[i] <= '0;
      end
    end else if (ptr_we) begin
      ptr_tab_r[port_r] <= ptr_wdata;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scs_pkg::ST_IDLE;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    ptr_r      <= ptr_nxt;
    code_r     <= code_nxt;
    port_r     <= port_nxt;
    rdy_r      <= rdy_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    code_nxt       = code_r;
    port_nxt       = port_r;
    rdy_nxt        = rdy_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    rd_addr        = idx_r[ADDR_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[ADDR_W-1:0];
    wr_data        = rd_data_r;
    ptr_we         = 1'b0;
    ptr_wdata      = ptr_r;

    unique case (state_r)
      scs_pkg::ST_IDLE: begin
        if (start) begin
          code_nxt = TYPE_BITS'(in_data.type_code);
          port_nxt = PIDX_W'(in_data.port);
          rdy_nxt  = in_data.downstream_ready;
          idx_nxt  = '0;
          if (in_data.command == scs_pkg::CMD_ADD) begin
            state_nxt = scs_pkg::ST_SRCH_RD;
          end else if (port_ok && (total_r != '0)) begin
            ptr_nxt   = ptr_tab_r[PIDX_W'(in_data.port)];
            state_nxt = scs_pkg::ST_MOD;
          end else begin
            // bad port, disabled port or empty table
            out_strobe_nxt            = 1'b1;
            out_data_nxt.status       = scs_pkg::STAT_NOTHING;
            out_data_nxt.item_type    = '0;
            out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r);
          end
        end
      end

      // search: read entry idx
      scs_pkg::ST_SRCH_RD: begin
        if (idx_r == total_r) begin
          // no larger or equal entry, new entry goes at the end unless the table is full
          if (tab_full) begin
            out_strobe_nxt            = 1'b1;
            out_data_nxt.status       = scs_pkg::STAT_DROPPED;
            out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(code_r);
            out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r);
            state_nxt                 = scs_pkg::ST_IDLE;
          end else begin
            pos_nxt   = total_r;
            state_nxt = scs_pkg::ST_INS;
          end
        end else begin
          rd_addr   = idx_r[ADDR_W-1:0];
          state_nxt = scs_pkg::ST_SRCH_CHK;
        end
      end

      // search: compare entry idx against the code
      scs_pkg::ST_SRCH_CHK: begin
        if (rd_type == code_r) begin
          out_strobe_nxt            = 1'b1;
          out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(code_r);
          out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r);
          state_nxt                 = scs_pkg::ST_IDLE;
          if (&rd_count) begin
            out_data_nxt.status = scs_pkg::STAT_DROPPED;
          end else begin
            out_data_nxt.status = scs_pkg::STAT_ADDED;
            wr_en   = 1'b1;
            wr_addr = idx_r[ADDR_W-1:0];
            wr_data = {rd_type, rd_count + COUNT_BITS'(1)};
          end
        end else if (rd_type > code_r) begin
          if (tab_full) begin
            out_strobe_nxt            = 1'b1;
            out_data_nxt.status       = scs_pkg::STAT_DROPPED;
            out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(code_r);
            out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r);
            state_nxt                 = scs_pkg::ST_IDLE;
          end else begin
            pos_nxt   = idx_r;
            idx_nxt   = total_r;
            state_nxt = scs_pkg::ST_SHUP_RD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = scs_pkg::ST_SRCH_RD;
        end
      end

      // shift up: read entry idx-1
      scs_pkg::ST_SHUP_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = scs_pkg::ST_INS;
        end else begin
          rd_addr   = ADDR_W'(idx_r - CNT_W'(1));
          state_nxt = scs_pkg::ST_SHUP_WR;
        end
      end

      // shift up: move it to entry idx
      scs_pkg::ST_SHUP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[ADDR_W-1:0];
        wr_data   = rd_data_r;
        idx_nxt   = idx_r - CNT_W'(1);
        state_nxt = scs_pkg::ST_SHUP_RD;
      end

      // place the new entry with a count of one
      scs_pkg::ST_INS: begin
        wr_en                     = 1'b1;
        wr_addr                   = pos_r[ADDR_W-1:0];
        wr_data                   = {code_r, COUNT_BITS'(1)};
        total_nxt                 = total_r + CNT_W'(1);
        out_strobe_nxt            = 1'b1;
        out_data_nxt.status       = scs_pkg::STAT_ADDED;
        out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(code_r);
        out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r + CNT_W'(1));
        state_nxt                 = scs_pkg::ST_IDLE;
      end

      // pointer modulo entry count by repeated subtraction
      scs_pkg::ST_MOD: begin
        if (ptr_r >= total_r) begin
          ptr_nxt = ptr_r - total_r;
        end else begin
          rd_addr   = ptr_r[ADDR_W-1:0];
          state_nxt = scs_pkg::ST_DISP_CHK;
        end
      end

      // offer the entry at the pointer
      scs_pkg::ST_DISP_CHK: begin
        code_nxt                  = rd_type;
        out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(rd_type);
        out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r);
        ptr_we                    = 1'b1;
        if (!rdy_r) begin
          ptr_wdata           = ptr_r;
          out_strobe_nxt      = 1'b1;
          out_data_nxt.status = scs_pkg::STAT_NOT_TAKEN;
          state_nxt           = scs_pkg::ST_IDLE;
        end else if (count_dec != '0) begin
          wr_en               = 1'b1;
          wr_addr             = ptr_r[ADDR_W-1:0];
          wr_data             = {rd_type, count_dec};
          ptr_wdata           = ptr_r + CNT_W'(1);
          out_strobe_nxt      = 1'b1;
          out_data_nxt.status = scs_pkg::STAT_DISPENSED;
          state_nxt           = scs_pkg::ST_IDLE;
        end else begin
          // entry emptied, close the gap
          ptr_we    = 1'b0;
          idx_nxt   = ptr_r;
          state_nxt = scs_pkg::ST_SHDN_RD;
        end
      end

      // shift down: read entry idx+1
      scs_pkg::ST_SHDN_RD: begin
        if ((idx_r + CNT_W'(1)) >= total_r) begin
          total_nxt                 = total_r - CNT_W'(1);
          ptr_we                    = 1'b1;
          ptr_wdata                 = (total_r == CNT_W'(1)) ? ptr_r : ptr_r + CNT_W'(1);
          out_strobe_nxt            = 1'b1;
          out_data_nxt.status       = scs_pkg::STAT_DISPENSED;
          out_data_nxt.item_type    = scs_pkg::TYPE_FIELD_W'(code_r);
          out_data_nxt.entries_used = scs_pkg::ENTRIES_W'(total_r - CNT_W'(1));
          state_nxt                 = scs_pkg::ST_IDLE;
        end else begin
          rd_addr   = ADDR_W'(idx_r + CNT_W'(1));
          state_nxt = scs_pkg::ST_SHDN_WR;
        end
      end

      // shift down: move it to entry idx
      scs_pkg::ST_SHDN_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[ADDR_W-1:0];
        wr_data   = rd_data_r;
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = scs_pkg::ST_SHDN_RD;
      end

      default: begin
        state_nxt = scs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
